// ===== src/fdfr_pkg.sv =====
// Package for the flag-delimited frame receiver.
// Holds shared types, event codes and default constants; no dependencies.
package fdfr_pkg;

    localparam logic [7:0]  FLAG_BYTE         = 8'h7E;
    localparam logic [15:0] GAP_LIMIT_RESET   = 16'd300;
    localparam int          BUFFER_BYTES_DEF  = 64;
    localparam int          GAP_W             = 17;
    localparam int          QUEUE_DEPTH       = 2;
    localparam int          QUEUE_AW          = 1;

    // Result kinds, as seen on the output channel.
    typedef enum logic [2:0] {
        EV_NONE     = 3'd0,
        EV_STORED   = 3'd1,
        EV_COMPLETE = 3'd2,
        EV_NACK     = 3'd3,
        EV_OVERFLOW = 3'd4,
        EV_START    = 3'd5
    } t_event;

    // Classified input item, as held in the front-to-back queue.
    typedef enum logic [1:0] {
        CMD_TICK = 2'd0,
        CMD_FLAG = 2'd1,
        CMD_DATA = 2'd2
    } t_cmd_op;

    typedef struct packed {
        t_cmd_op    op;
        logic [7:0] data;
    } t_cmd;

endpackage

// ===== src/fdfr_in_if.sv =====
// Input channel of the frame receiver: one received byte or one tick per beat.
// No dependencies.
interface fdfr_in_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [7:0] rx_byte;

    modport source (output valid, output operation, output rx_byte, input ready);
    modport sink   (input valid, input operation, input rx_byte, output ready);
endinterface

// ===== src/fdfr_out_if.sv =====
// Output channel of the frame receiver: one event per beat.
// No dependencies.
interface fdfr_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] event_kind;
    logic [5:0] store_index;
    logic [7:0] store_byte;
    logic [6:0] frame_length;

    modport source (output valid, output event_kind, output store_index,
                    output store_byte, output frame_length, input ready);
    modport sink   (input valid, input event_kind, input store_index,
                    input store_byte, input frame_length, output ready);
endinterface

// ===== src/flag_delimited_frame_receiver_core.sv =====
// Top level of the flag-delimited frame receiver.
// Depends on fdfr_pkg, fdfr_in_if, fdfr_out_if, fdfr_front, fdfr_queue, fdfr_back.
//
// Usage:
//   i_in carries one beat per received byte (operation = 0) or per timer tick
//   (operation = 1). Frames open and close on the flag byte 0x7E. Every input
//   beat yields exactly one event beat on o_out: byte stored (with buffer
//   index and data), frame start, frame complete (with length), timeout NACK,
//   overflow drop, or none (ticks and stray bytes outside a frame).
//   i_cfg_we / i_cfg_wdata write the 16-bit inter-byte gap limit in ticks;
//   write it only while the block is idle.
// Timing:
//   One beat per cycle sustained while o_out.ready stays high. An accepted beat
//   lands in a two-entry queue and then moves into the output register, whose
//   event is presented on o_out; a stall on o_out can hold it in the queue.
//   The single frame-state update in the back end sets the rate: one beat per
//   cycle when the output is not stalled.
// Reset:
//   Synchronous, active low. Clears the queue and output valid, leaves the
//   receiver idle with fill index and gap counter zero, gap limit 300.
// Stall:
//   When o_out.ready is low with an event valid, the output register holds it,
//   the back end stops popping, and the queue fills; i_in.ready drops once the
//   queue is full and rises again as soon as an entry frees up.
module flag_delimited_frame_receiver_core #(
    parameter int BufferBytes = fdfr_pkg::BUFFER_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    fdfr_in_if.sink     i_in,
    fdfr_out_if.source  o_out
);
    import fdfr_pkg::*;

    logic q_full;
    logic q_push;
    logic q_valid;
    logic q_pop;
    t_cmd push_cmd;
    t_cmd head_cmd;

    // Classify incoming beats.
    fdfr_front u_front (
        .i_in     (i_in),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_cmd    (push_cmd)
    );

    // Decouple acceptance from execution.
    fdfr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (push_cmd),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (head_cmd)
    );

    // Advance frame state and register the event.
    fdfr_back #(
        .BufferBytes (BufferBytes)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_q_valid   (q_valid),
        .i_q_cmd     (head_cmd),
        .o_q_pop     (q_pop),
        .o_out       (o_out)
    );
endmodule

// ===== src/fdfr_front.sv =====
// Front end of the frame receiver: accepts input beats and classifies them.
// Depends on fdfr_pkg and fdfr_in_if.
module fdfr_front (
    fdfr_in_if.sink       i_in,
    input  logic          i_q_full,
    output logic          o_push,
    output fdfr_pkg::t_cmd o_cmd
);
    import fdfr_pkg::*;

    assign i_in.ready = !i_q_full;
    assign o_push     = i_in.valid && !i_q_full;

    // Tick, flag or data byte.
    always_comb begin
        o_cmd.data = i_in.rx_byte;
        if (i_in.operation) begin
            o_cmd.op = CMD_TICK;
        end else if (i_in.rx_byte == FLAG_BYTE) begin
            o_cmd.op = CMD_FLAG;
        end else begin
            o_cmd.op = CMD_DATA;
        end
    end
endmodule

// ===== src/fdfr_queue.sv =====
// Short queue between front and back of the frame receiver.
// Depends on fdfr_pkg.
module fdfr_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  fdfr_pkg::t_cmd i_cmd,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_valid,
    output fdfr_pkg::t_cmd o_cmd
);
    import fdfr_pkg::*;

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_cmd                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr;
    logic [QUEUE_AW-1:0] r_rd;
    logic [CW-1:0]       r_cnt;

    assign o_full  = (r_cnt == CW'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end
endmodule

// ===== src/fdfr_back.sv =====
// Back end of the frame receiver: frame state, gap counter and output register.
// Depends on fdfr_pkg and fdfr_out_if.
module fdfr_back #(
    parameter int BufferBytes = fdfr_pkg::BUFFER_BYTES_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic [15:0]    i_cfg_wdata,
    input  logic           i_q_valid,
    input  fdfr_pkg::t_cmd i_q_cmd,
    output logic           o_q_pop,
    fdfr_out_if.source     o_out
);
    import fdfr_pkg::*;

    localparam int FW = $clog2(BufferBytes + 1);
    localparam int OW = (FW > 7) ? FW : 7;

    logic             r_receiving, n_receiving;
    logic [FW-1:0]    r_fill, n_fill;
    logic [GAP_W-1:0] r_gap, n_gap;
    logic [15:0]      r_gap_limit;

    logic             r_ov;
    t_event           r_kind, n_kind;
    logic [5:0]       r_idx, n_idx;
    logic [7:0]       r_byte, n_byte;
    logic [6:0]       r_len, n_len;

    logic             take;
    logic [OW-1:0]    fill_wide;

    assign take      = i_q_valid && (!r_ov || o_out.ready);
    assign o_q_pop   = take;
    assign fill_wide = OW'(r_fill);

    always_comb begin
        n_receiving = r_receiving;
        n_fill      = r_fill;
        n_gap       = r_gap;
        n_kind      = EV_NONE;
        n_idx       = '0;
        n_byte      = '0;
        n_len       = '0;
        case (i_q_cmd.op)
            CMD_TICK: begin
                // saturate, never wrap
                if (r_gap != '1) begin
                    n_gap = r_gap + 1'b1;
                end
            end
            CMD_FLAG: begin
                n_gap       = '0;
                n_receiving = !r_receiving;
                if (!r_receiving) begin
                    n_fill = '0;
                    n_kind = EV_START;
                end else begin
                    n_kind = EV_COMPLETE;
                    n_len  = fill_wide[6:0];
                end
            end
            CMD_DATA: begin
                if (r_receiving) begin
                    n_gap = '0;
                    if (r_gap > {1'b0, r_gap_limit}) begin
                        n_receiving = 1'b0;
                        n_kind      = EV_NACK;
                    end else if (r_fill < FW'(BufferBytes)) begin
                        n_fill = r_fill + 1'b1;
                        n_kind = EV_STORED;
                        n_idx  = fill_wide[5:0];
                        n_byte = i_q_cmd.data;
                    end else begin
                        n_kind = EV_OVERFLOW;
                    end
                end
            end
            default: begin
                n_kind = EV_NONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_receiving <= 1'b0;
            r_fill      <= '0;
            r_gap       <= '0;
            r_gap_limit <= GAP_LIMIT_RESET;
            r_ov        <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_gap_limit <= i_cfg_wdata;
            end
            if (take) begin
                r_receiving <= n_receiving;
                r_fill      <= n_fill;
                r_gap       <= n_gap;
                r_ov        <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_kind <= n_kind;
            r_idx  <= n_idx;
            r_byte <= n_byte;
            r_len  <= n_len;
        end
    end

    assign o_out.valid        = r_ov;
    assign o_out.event_kind   = r_kind;
    assign o_out.store_index  = r_idx;
    assign o_out.store_byte   = r_byte;
    assign o_out.frame_length = r_len;
endmodule
